/* design/dns_response_frame_classifier_macros.svh */
// Assertion macros shared by the DNS response frame classifier.
`ifndef DNS_RESPONSE_FRAME_CLASSIFIER_MACROS_SVH
`define DNS_RESPONSE_FRAME_CLASSIFIER_MACROS_SVH

// Checks a same-cycle implication while reset is low.
`define DNSRFC_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Checks a next-cycle implication, also across reset.
`define DNSRFC_ASSERT_NEXT(label, clk, pre, post, msg) \
   label: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

/* design/dnsrfc_pkg.sv */
// Types and constants shared by the DNS response frame classifier modules.
package dnsrfc_pkg;

   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
   localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
   localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
   localparam logic [15:0] DNS_HDR_BYTES = 16'd12;
   localparam logic [15:0] MIN_UDP_LENGTH = UDP_HDR_BYTES + DNS_HDR_BYTES;
   localparam logic [6:0] PAYLOAD_BASE = 7'(ETH_HDR_BYTES + UDP_HDR_BYTES);
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [3:0] IP_VERSION_4 = 4'd4;
   localparam logic [3:0] IP_VERSION_6 = 4'd6;
   localparam logic [5:0] IPV4_MIN_HDR_BYTES = 6'd20;
   localparam logic [5:0] IPV6_HDR_BYTES = 6'd40;

   localparam logic [15:0] CAPTURE_LIMIT_RESET = 16'd512;
   localparam logic [15:0] SERVICE_PORT_RESET = 16'd53;

   localparam logic CSR_CAPTURE_LIMIT = 1'b0;
   localparam logic CSR_SERVICE_PORT = 1'b1;

   localparam int MID_QUEUE_DEPTH = 4;
   localparam int OUT_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [16:0] total;
      logic [5:0]  ip_header_len;
      logic        headers_ok;
      logic        is_v4;
      logic        is_v6;
      logic [15:0] src_port;
      logic [15:0] dest_port;
      logic [15:0] udp_length;
      logic [63:0] source_addr_high;
      logic [63:0] source_addr_low;
      logic [63:0] dest_addr_high;
      logic [63:0] dest_addr_low;
   } frame_summary_type;

   typedef struct packed {
      logic        is_dns_response;
      logic        ip_is_v6;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [63:0] source_addr_high;
      logic [63:0] source_addr_low;
      logic [63:0] dest_addr_high;
      logic [63:0] dest_addr_low;
      logic [6:0]  data_offset;
      logic [15:0] capture_len;
   } result_type;

endpackage

/* design/dnsrfc_queue.sv */
// Small register-based first-in first-out queue.
module dnsrfc_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/dnsrfc_front.sv */
// Byte-wise header parser that builds one summary per frame.
module dnsrfc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    data_byte,
   input  logic                          frame_last,
   output logic                          summary_push,
   output dnsrfc_pkg::frame_summary_type summary
);
   import dnsrfc_pkg::*;

   localparam logic [15:0] POS_ETYPE_HI = 16'd12;
   localparam logic [15:0] POS_ETYPE_LO = 16'd13;
   localparam logic [15:0] POS_V4_PROTO = 16'd23;
   localparam logic [15:0] POS_V6_NEXT = 16'd20;

   logic [15:0] byte_count_ff, byte_count_in;
   logic [15:0] ether_type_ff, ether_type_in;
   logic [5:0]  ip_header_len_ff, ip_header_len_in;
   logic        headers_ok_ff, headers_ok_in;
   logic [15:0] udp_length_ff, udp_length_in;
   logic [15:0] src_port_ff, src_port_in;
   logic [15:0] dest_port_ff, dest_port_in;
   logic [63:0] src_high_ff, src_high_in;
   logic [63:0] src_low_ff, src_low_in;
   logic [63:0] dst_high_ff, dst_high_in;
   logic [63:0] dst_low_ff, dst_low_in;
   logic [15:0] pos;
   logic [15:0] udp_pos;
   logic        is_v4;
   logic        is_v6;
   logic        in_udp;

   assign summary_push = accept && frame_last;

   always_comb begin
      pos = byte_count_ff;
      byte_count_in = (byte_count_ff == 16'hFFFF) ? byte_count_ff : byte_count_ff + 1'b1;
      ether_type_in = ether_type_ff;
      ip_header_len_in = ip_header_len_ff;
      headers_ok_in = headers_ok_ff;
      udp_length_in = udp_length_ff;
      src_port_in = src_port_ff;
      dest_port_in = dest_port_ff;
      src_high_in = src_high_ff;
      src_low_in = src_low_ff;
      dst_high_in = dst_high_ff;
      dst_low_in = dst_low_ff;

      if (pos == POS_ETYPE_HI) begin
         ether_type_in = {data_byte, 8'h00};
      end else if (pos == POS_ETYPE_LO) begin
         ether_type_in = {ether_type_ff[15:8], data_byte};
      end

      is_v4 = (pos >= ETH_HDR_BYTES) && (ether_type_ff == ETH_TYPE_IPV4);
      is_v6 = (pos >= ETH_HDR_BYTES) && (ether_type_ff == ETH_TYPE_IPV6);

      if (pos == ETH_HDR_BYTES) begin
         if (is_v4) begin
            ip_header_len_in = {data_byte[3:0], 2'b00};
            if (data_byte[7:4] != IP_VERSION_4 || ip_header_len_in < IPV4_MIN_HDR_BYTES) begin
               headers_ok_in = 1'b0;
            end
         end else if (is_v6) begin
            ip_header_len_in = IPV6_HDR_BYTES;
            if (data_byte[7:4] != IP_VERSION_6) begin
               headers_ok_in = 1'b0;
            end
         end
      end

      if (is_v4) begin
         if (pos == POS_V4_PROTO && data_byte != PROTO_UDP) begin
            headers_ok_in = 1'b0;
         end
         if (pos inside {[16'd26:16'd29]}) begin
            src_low_in = {src_low_ff[55:0], data_byte};
         end else if (pos inside {[16'd30:16'd33]}) begin
            dst_low_in = {dst_low_ff[55:0], data_byte};
         end
      end else if (is_v6) begin
         if (pos == POS_V6_NEXT && data_byte != PROTO_UDP) begin
            headers_ok_in = 1'b0;
         end
         if (pos inside {[16'd22:16'd29]}) begin
            src_high_in = {src_high_ff[55:0], data_byte};
         end else if (pos inside {[16'd30:16'd37]}) begin
            src_low_in = {src_low_ff[55:0], data_byte};
         end else if (pos inside {[16'd38:16'd45]}) begin
            dst_high_in = {dst_high_ff[55:0], data_byte};
         end else if (pos inside {[16'd46:16'd53]}) begin
            dst_low_in = {dst_low_ff[55:0], data_byte};
         end
      end

      udp_pos = pos - ETH_HDR_BYTES - {10'b0, ip_header_len_ff};
      in_udp = (is_v4 || is_v6) && (pos > ETH_HDR_BYTES)
               && (pos >= ETH_HDR_BYTES + {10'b0, ip_header_len_ff});
      if (in_udp) begin
         if (udp_pos < 16'd2) begin
            src_port_in = {src_port_ff[7:0], data_byte};
         end else if (udp_pos < 16'd4) begin
            dest_port_in = {dest_port_ff[7:0], data_byte};
         end else if (udp_pos < 16'd6) begin
            udp_length_in = {udp_length_ff[7:0], data_byte};
         end
      end

      summary.total = {1'b0, pos} + 17'd1;
      summary.ip_header_len = ip_header_len_in;
      summary.headers_ok = headers_ok_in;
      summary.is_v4 = is_v4;
      summary.is_v6 = is_v6;
      summary.src_port = src_port_in;
      summary.dest_port = dest_port_in;
      summary.udp_length = udp_length_in;
      summary.source_addr_high = src_high_in;
      summary.source_addr_low = src_low_in;
      summary.dest_addr_high = dst_high_in;
      summary.dest_addr_low = dst_low_in;

      if (frame_last) begin
         byte_count_in = '0;
         ether_type_in = '0;
         ip_header_len_in = '0;
         headers_ok_in = 1'b1;
         udp_length_in = '0;
         src_port_in = '0;
         dest_port_in = '0;
         src_high_in = '0;
         src_low_in = '0;
         dst_high_in = '0;
         dst_low_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         ether_type_ff <= '0;
         ip_header_len_ff <= '0;
         headers_ok_ff <= 1'b1;
         udp_length_ff <= '0;
         src_port_ff <= '0;
         dest_port_ff <= '0;
         src_high_ff <= '0;
         src_low_ff <= '0;
         dst_high_ff <= '0;
         dst_low_ff <= '0;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
         ether_type_ff <= ether_type_in;
         ip_header_len_ff <= ip_header_len_in;
         headers_ok_ff <= headers_ok_in;
         udp_length_ff <= udp_length_in;
         src_port_ff <= src_port_in;
         dest_port_ff <= dest_port_in;
         src_high_ff <= src_high_in;
         src_low_ff <= src_low_in;
         dst_high_ff <= dst_high_in;
         dst_low_ff <= dst_low_in;
      end
   end

endmodule

/* design/dnsrfc_back.sv */
// Verdict pipeline that turns frame summaries into result items.
module dnsrfc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [15:0]                   capture_limit,
   input  logic [15:0]                   service_port,
   input  logic                          summary_empty,
   input  dnsrfc_pkg::frame_summary_type summary,
   output logic                          summary_pop,
   input  logic                          result_full,
   output logic                          result_push,
   output dnsrfc_pkg::result_type        result
);
   import dnsrfc_pkg::*;

   typedef struct packed {
      frame_summary_type frame;
      logic [15:0]       helper;
      logic [6:0]        offset;
      logic              pre_ok;
   } stage_type;

   logic        s1_valid_ff, s1_valid_in;
   stage_type   s1_ff, s1_in;
   logic        s1_ready;
   logic [15:0] payload;
   logic [16:0] needed;
   logic        ok;

   assign result_push = s1_valid_ff && !result_full;
   assign s1_ready = !s1_valid_ff || !result_full;
   assign summary_pop = !summary_empty && s1_ready;
   assign s1_valid_in = summary_pop || (s1_valid_ff && result_full);

   always_comb begin
      payload = (summary.udp_length >= UDP_HDR_BYTES) ? summary.udp_length - UDP_HDR_BYTES
                                                     : '0;
      s1_in.frame = summary;
      s1_in.helper = (payload > capture_limit) ? capture_limit : payload;
      s1_in.offset = PAYLOAD_BASE + {1'b0, summary.ip_header_len};
      s1_in.pre_ok = summary.headers_ok && (summary.is_v4 || summary.is_v6)
                     && (summary.src_port == service_port)
                     && (summary.udp_length >= MIN_UDP_LENGTH)
                     && (s1_in.helper != '0);
   end

   always_comb begin
      needed = {10'b0, s1_ff.offset} + {1'b0, s1_ff.helper};
      ok = s1_ff.pre_ok && (s1_ff.frame.total >= needed);
      result = '0;
      if (ok) begin
         result.is_dns_response = 1'b1;
         result.ip_is_v6 = s1_ff.frame.is_v6;
         result.src_port = s1_ff.frame.src_port;
         result.dst_port = s1_ff.frame.dest_port;
         if (s1_ff.frame.is_v6) begin
            result.source_addr_high = s1_ff.frame.source_addr_high;
            result.source_addr_low = s1_ff.frame.source_addr_low;
            result.dest_addr_high = s1_ff.frame.dest_addr_high;
            result.dest_addr_low = s1_ff.frame.dest_addr_low;
         end else begin
            result.source_addr_low = {32'b0, s1_ff.frame.source_addr_low[31:0]};
            result.dest_addr_low = {32'b0, s1_ff.frame.dest_addr_low[31:0]};
         end
         result.data_offset = s1_ff.offset;
         result.capture_len = s1_ff.helper;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (summary_pop) begin
         s1_ff <= s1_in;
      end
   end

endmodule

/* design/dns_response_frame_classifier.sv */
// Top level of the DNS response frame classifier.
//
// Frame bytes enter on the req_ queue port, first byte at the Ethernet
// destination address; req_frame_last marks the final byte. An item is taken
// at each clock edge with req_push high and req_full low, one per cycle.
// Each frame yields exactly one result item on the rsp_ queue port, shown
// while rsp_empty is low and taken when rsp_pop is high. A rejected frame
// reports is_dns_response low and every other field zero.
// The parser handles one byte per cycle; the summary queue and one verdict
// register stand behind it, so a result goes through both and then the result
// queue before it is shown, and results can leave one per cycle when popped.
// Frame summaries wait in a four-entry queue and results in a two-entry
// queue. When the receiver stops popping, these fill and req_full rises;
// bytes of a frame are held off only while the summary queue is full.
// The csr_ port writes capture_limit (index 0) or service_port (index 1) at
// an edge with csr_write_enable high; write only while no frame is in flight.
// Synchronous reset empties both queues, clears the parser state and sets
// the registers to a capture limit of 512 and a service port of 53.
`include "dns_response_frame_classifier_macros.svh"

module dns_response_frame_classifier #(
   parameter int MID_DEPTH = dnsrfc_pkg::MID_QUEUE_DEPTH,
   parameter int OUT_DEPTH = dnsrfc_pkg::OUT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_is_dns_response,
   output logic        rsp_ip_is_v6,
   output logic [15:0] rsp_src_port,
   output logic [15:0] rsp_dst_port,
   output logic [63:0] rsp_source_addr_high,
   output logic [63:0] rsp_source_addr_low,
   output logic [63:0] rsp_dest_addr_high,
   output logic [63:0] rsp_dest_addr_low,
   output logic [6:0]  rsp_data_offset,
   output logic [15:0] rsp_capture_len,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);
   import dnsrfc_pkg::*;

   logic [15:0]       capture_limit_ff, capture_limit_in;
   logic [15:0]       service_port_ff, service_port_in;
   logic              req_accept;
   logic              summary_push;
   frame_summary_type summary_in;
   frame_summary_type summary_out;
   logic              mid_full;
   logic              mid_empty;
   logic              mid_pop;
   logic              result_push;
   logic              out_full;
   result_type        result_in;
   result_type        result_out;
   logic              shown_reject;
   logic              shown_accept;
   logic              fields_zero;
   logic              accept_rules;

   assign req_full = mid_full;
   assign req_accept = req_push && !mid_full;

   always_comb begin
      capture_limit_in = capture_limit_ff;
      service_port_in = service_port_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CAPTURE_LIMIT: capture_limit_in = csr_write_data;
            CSR_SERVICE_PORT: service_port_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capture_limit_ff <= CAPTURE_LIMIT_RESET;
         service_port_ff <= SERVICE_PORT_RESET;
      end else begin
         capture_limit_ff <= capture_limit_in;
         service_port_ff <= service_port_in;
      end
   end

   dnsrfc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .data_byte    (req_data_byte),
      .frame_last   (req_frame_last),
      .summary_push (summary_push),
      .summary      (summary_in)
   );

   dnsrfc_queue #(
      .WIDTH ($bits(frame_summary_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (summary_push),
      .push_data (summary_in),
      .full      (mid_full),
      .pop       (mid_pop),
      .empty     (mid_empty),
      .pop_data  (summary_out)
   );

   dnsrfc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .capture_limit (capture_limit_ff),
      .service_port  (service_port_ff),
      .summary_empty (mid_empty),
      .summary       (summary_out),
      .summary_pop   (mid_pop),
      .result_full   (out_full),
      .result_push   (result_push),
      .result        (result_in)
   );

   dnsrfc_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result_in),
      .full      (out_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (result_out)
   );

   assign rsp_is_dns_response = result_out.is_dns_response;
   assign rsp_ip_is_v6 = result_out.ip_is_v6;
   assign rsp_src_port = result_out.src_port;
   assign rsp_dst_port = result_out.dst_port;
   assign rsp_source_addr_high = result_out.source_addr_high;
   assign rsp_source_addr_low = result_out.source_addr_low;
   assign rsp_dest_addr_high = result_out.dest_addr_high;
   assign rsp_dest_addr_low = result_out.dest_addr_low;
   assign rsp_data_offset = result_out.data_offset;
   assign rsp_capture_len = result_out.capture_len;

   assign shown_reject = !rsp_empty && !rsp_is_dns_response;
   assign shown_accept = !rsp_empty && rsp_is_dns_response;
   assign fields_zero = !rsp_ip_is_v6 && rsp_src_port == 16'd0 && rsp_dst_port == 16'd0
                        && rsp_source_addr_high == 64'd0 && rsp_source_addr_low == 64'd0
                        && rsp_dest_addr_high == 64'd0 && rsp_dest_addr_low == 64'd0
                        && rsp_data_offset == 7'd0 && rsp_capture_len == 16'd0;
   assign accept_rules = rsp_capture_len != 16'd0 && rsp_capture_len <= capture_limit_ff
                         && rsp_src_port == service_port_ff;

   `DNSRFC_ASSERT_NEXT(a_reset_empty, clock, reset, rsp_empty && !req_full, "reset left items")
   `DNSRFC_ASSERT_IMPLY(a_reject_zero, clock, reset, shown_reject, fields_zero, "reject not zero")
   `DNSRFC_ASSERT_IMPLY(a_accept_rules, clock, reset, shown_accept, accept_rules, "bad accept")

endmodule
